/* rtl/core/txc_pkg.sv */
`timescale 1ns / 1ps

package txc_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] TAB_CHAR     = 8'h09;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic exec;
    logic read;
    logic clear_wr;
    logic blank_wr;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic row_last;
    logic scroll;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/txc_stream_if.sv */
`timescale 1ns / 1ps

interface txc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_in;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, output op, output char_in, output read_row,
                  output read_col, input ready);
  modport sink (input valid, input op, input char_in, input read_row,
                input read_col, output ready);
endinterface

interface txc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [10:0] cursor_pos;
  logic        scrolled;

  modport source (output valid, output cell_char, output cell_attr, output cursor_row,
                  output cursor_col, output cursor_pos, output scrolled, input ready);
  modport sink (input valid, input cell_char, input cell_attr, input cursor_row,
                input cursor_col, input cursor_pos, input scrolled, output ready);
endinterface

/* rtl/core/text_console_terminal_unit.sv */
`timescale 1ns / 1ps

// Teletype text console over a ROWS x COLUMNS screen of 16-bit cells.
// in_if carries one item: op (put character or read only), the character
// byte and a read position. out_if returns one item per input item: the cell
// at the read position after the step, the cursor (row, column, linear
// position) and a flag set when the step scrolled the screen.
// cfg_we/cfg_data write the attribute byte stored with new and blanked cells.
// Each item passes through the states EXEC (cursor update, cell write and
// memory read) and RESP (output register load); a new item is taken as the
// previous result is loaded. A step that scrolls blanks the freed bottom row
// in SCROLL and reads in READ; rows are kept in a circular order in one single-port-write, single-port-read memory.
// Reset: the cursor goes home and the attribute returns to 0x0F; then the
// whole screen is swept to spaces with attribute 0x0F, one cell per cycle,
// with in_if.ready low. Attribute writes are taken during the sweep.
// Stall: a result waits in the output register while out_if.ready is low;
// the next item is still taken and processed up to its memory read, then
// holds until the output register frees.

module text_console_terminal_unit import txc_pkg::*; #(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  txc_in_if.sink     in_if,
  txc_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign in_if.ready = cmd.in_ready;

  txc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  txc_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_op          (in_if.op),
    .in_char_in     (in_if.char_in),
    .in_read_row    (in_if.read_row),
    .in_read_col    (in_if.read_col),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_cell_char  (out_if.cell_char),
    .out_cell_attr  (out_if.cell_attr),
    .out_cursor_row (out_if.cursor_row),
    .out_cursor_col (out_if.cursor_col),
    .out_cursor_pos (out_if.cursor_pos),
    .out_scrolled   (out_if.scrolled)
  );

endmodule

/* rtl/core/txc_ctrl.sv */
`timescale 1ns / 1ps

module txc_ctrl import txc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = sts.scroll ? ST_SCROLL : ST_RESP;
      end
      ST_SCROLL: begin
        if (sts.row_last) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) state_nxt = in_valid ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_SCROLL: begin
        cmd.blank_wr = 1'b1;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_RESP: begin
        cmd.load     = sts.out_free;
        cmd.in_ready = sts.out_free;
        cmd.accept   = sts.out_free && in_valid;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_scroll_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && sts.scroll) |=> (state_r == ST_SCROLL))
    else $error("scroll did not enter blanking");
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_EXEC))
    else $error("accepted item not executed");
  a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !cmd.in_ready)
    else $error("input taken during screen clear");
`endif

endmodule

/* rtl/core/txc_datapath.sv */
`timescale 1ns / 1ps

module txc_datapath import txc_pkg::*; #(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_op,
  input  logic [7:0]  in_char_in,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic [10:0] out_cursor_pos,
  output logic        out_scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int TW    = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int SW    = CW + 5;

  logic [15:0] mem [CELLS];

  logic [7:0]    attr_r;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [TW-1:0] mod_r, mod_nxt;
  logic [RW-1:0] base_r, base_nxt;
  logic [AW-1:0] cnt_r;

  logic          op_r;
  logic [7:0]    char_r;
  logic [4:0]    rrow_r;
  logic [6:0]    rcol_r;

  logic [15:0]   rd_data_r;
  logic          fwd_r;
  logic [15:0]   fwd_cell_r;
  logic          off_r;
  logic          scr_r;

  logic          out_valid_r;
  logic [7:0]    cell_char_r;
  logic [7:0]    cell_attr_r;
  logic [4:0]    cursor_row_r;
  logic [6:0]    cursor_col_r;
  logic [10:0]   cursor_pos_r;
  logic          scrolled_r;

  logic          is_put, is_nl, is_tab, is_chr;
  logic          adv_row, scroll_c;
  logic [SW-1:0] tab_sum;
  logic [RW:0]   cur_sum, rd_sum;
  logic [RW-1:0] cur_prow, rd_prow, blank_row;
  logic [AW-1:0] cur_addr, rd_addr, blank_addr;
  logic          rd_in_range;
  logic          exec_we, mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [15:0]   cell_q;

  assign is_put = (op_r == OP_PUT);
  assign is_nl  = is_put && (char_r == NEWLINE_CHAR);
  assign is_tab = is_put && (char_r == TAB_CHAR);
  assign is_chr = is_put && !is_nl && !is_tab;

  assign tab_sum = SW'(cur_col_r) + SW'(TAB_WIDTH) - SW'(mod_r);

  always_comb begin
    cur_col_nxt = cur_col_r;
    mod_nxt     = mod_r;
    adv_row     = 1'b0;
    if (is_nl) begin
      cur_col_nxt = '0;
      mod_nxt     = '0;
      adv_row     = 1'b1;
    end else if (is_tab) begin
      if (mod_r != '0) begin
        mod_nxt = '0;
        if (tab_sum >= SW'(COLUMNS)) begin
          cur_col_nxt = '0;
          adv_row     = 1'b1;
        end else begin
          cur_col_nxt = CW'(tab_sum);
        end
      end
    end else if (is_chr) begin
      if (cur_col_r == CW'(COLUMNS - 1)) begin
        cur_col_nxt = '0;
        mod_nxt     = '0;
        adv_row     = 1'b1;
      end else begin
        cur_col_nxt = cur_col_r + 1'b1;
        mod_nxt     = (mod_r == TW'(TAB_WIDTH - 1)) ? '0 : mod_r + 1'b1;
      end
    end
  end

  assign scroll_c    = adv_row && (cur_row_r == RW'(ROWS - 1));
  assign cur_row_nxt = (adv_row && !scroll_c) ? cur_row_r + 1'b1 : cur_row_r;
  assign base_nxt    = !scroll_c ? base_r :
                       (base_r == RW'(ROWS - 1)) ? '0 : base_r + 1'b1;

  assign cur_sum    = (RW+1)'(cur_row_r) + (RW+1)'(base_r);
  assign cur_prow   = (cur_sum >= (RW+1)'(ROWS)) ? RW'(cur_sum - (RW+1)'(ROWS)) : RW'(cur_sum);
  assign rd_sum     = (RW+1)'(rrow_r) + (RW+1)'(base_r);
  assign rd_prow    = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : RW'(rd_sum);
  assign blank_row  = (base_r == '0) ? RW'(ROWS - 1) : base_r - 1'b1;

  assign cur_addr   = AW'(cur_prow * COLUMNS + cur_col_r);
  assign rd_addr    = AW'(rd_prow * COLUMNS + rcol_r);
  assign blank_addr = AW'(blank_row * COLUMNS + cnt_r);

  assign rd_in_range = (32'(rrow_r) < ROWS) && (32'(rcol_r) < COLUMNS);

  assign exec_we = cmd.exec && is_chr;
  assign mem_we  = cmd.clear_wr || cmd.blank_wr || exec_we;
  assign mem_re  = cmd.exec || cmd.read;

  always_comb begin
    if (cmd.clear_wr) begin
      mem_waddr = cnt_r;
      mem_wdata = {RESET_ATTR, BLANK_CHAR};
    end else if (cmd.blank_wr) begin
      mem_waddr = blank_addr;
      mem_wdata = {attr_r, BLANK_CHAR};
    end else begin
      mem_waddr = cur_addr;
      mem_wdata = {attr_r, char_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r  <= mem[rd_addr];
      fwd_r      <= exec_we && (mem_waddr == rd_addr);
      fwd_cell_r <= mem_wdata;
      off_r      <= !rd_in_range;
    end
  end

  assign sts.clear_last = (cnt_r == AW'(CELLS - 1));
  assign sts.row_last   = (cnt_r == AW'(COLUMNS - 1));
  assign sts.scroll     = scroll_c;
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r    <= RESET_ATTR;
      cur_row_r <= '0;
      cur_col_r <= '0;
      mod_r     <= '0;
      base_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
      if (cmd.exec) begin
        cur_row_r <= cur_row_nxt;
        cur_col_r <= cur_col_nxt;
        mod_r     <= mod_nxt;
        base_r    <= base_nxt;
      end
      if (cmd.clear_wr) begin
        cnt_r <= sts.clear_last ? '0 : cnt_r + 1'b1;
      end else if (cmd.blank_wr) begin
        cnt_r <= sts.row_last ? '0 : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_op;
      char_r <= in_char_in;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
    if (cmd.exec) begin
      scr_r <= scroll_c;
    end
  end

  assign cell_q = off_r ? 16'h0000 : (fwd_r ? fwd_cell_r : rd_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cell_char_r  <= cell_q[7:0];
      cell_attr_r  <= cell_q[15:8];
      cursor_row_r <= 5'(cur_row_r);
      cursor_col_r <= 7'(cur_col_r);
      cursor_pos_r <= 11'(cur_row_r * COLUMNS + cur_col_r);
      scrolled_r   <= scr_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = cell_char_r;
  assign out_cell_attr  = cell_attr_r;
  assign out_cursor_row = cursor_row_r;
  assign out_cursor_col = cursor_col_r;
  assign out_cursor_pos = cursor_pos_r;
  assign out_scrolled   = scrolled_r;

`ifndef SYNTHESIS
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row_r) < ROWS)
    else $error("cursor row off screen");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_col_r) < COLUMNS)
    else $error("cursor column off screen");
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(base_r) < ROWS)
    else $error("row base out of range");
  a_tab_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && is_nl) |=> (mod_r == '0 && cur_col_r == '0))
    else $error("newline left tab phase or column set");
`endif

endmodule
